### sv/itp_pkg.sv
// Shared definitions for the infix-to-postfix converter: character codes,
// error codes, controller/datapath command and status structs, precedence.
// No dependencies.
package itp_pkg;

    localparam int DEF_STACK_DEPTH = 8;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_MUL    = 8'h2A;
    localparam logic [7:0] CH_ADD    = 8'h2B;
    localparam logic [7:0] CH_SUB    = 8'h2D;
    localparam logic [7:0] CH_DIV    = 8'h2F;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
    localparam logic [1:0] ERR_UNMATCHED = 2'd2;

    localparam logic [1:0] SRC_SYM  = 2'd0;
    localparam logic [1:0] SRC_TOP  = 2'd1;
    localparam logic [1:0] SRC_ZERO = 2'd2;

    typedef struct packed {
        logic       load;
        logic       push;
        logic       pop;
        logic       emit;
        logic [1:0] src;
        logic [1:0] err;
        logic       emit_last;
    } cmd_t;

    typedef struct packed {
        logic sym_is_lparen;
        logic sym_is_rparen;
        logic sym_is_op;
        logic last;
        logic stack_empty;
        logic stack_full;
        logic ops_zero;
        logic ops_one;
        logic open_zero;
        logic top_is_lparen;
        logic top_yields;
        logic out_free;
    } status_t;

    function automatic logic [1:0] prec(input logic [7:0] c);
        logic [1:0] p;
        p = 2'd0;
        if (c == CH_MUL || c == CH_DIV)
        begin
            p = 2'd2;
        end
        else if (c == CH_ADD || c == CH_SUB)
        begin
            p = 2'd1;
        end
        return p;
    endfunction

endpackage

### sv/itp_datapath.sv
// Datapath of the infix-to-postfix converter: operator stack memory, counts,
// input holding register and output register. Depends on itp_pkg.
module itp_datapath #(
    parameter int STACK_DEPTH = itp_pkg::DEF_STACK_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  itp_pkg::cmd_t   cmd,
    output itp_pkg::status_t status,
    input  logic [7:0]      in_symbol,
    input  logic            in_last,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_symbol,
    output logic            out_last,
    output logic [1:0]      out_error
);
    import itp_pkg::*;

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    logic [7:0]        mem [STACK_DEPTH];
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  open_reg, open_next;
    logic [CNT_W-1:0]  ops;
    logic [CNT_W-1:0]  rd_ptr;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [7:0]        top_reg;
    logic [7:0]        sym_reg;
    logic              last_reg;
    logic [7:0]        emit_data;
    logic              out_valid_reg;
    logic [7:0]        out_symbol_reg;
    logic              out_last_reg;
    logic [1:0]        out_error_reg;

    always_comb
    begin
        count_next = count_reg;
        open_next  = open_reg;
        if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
            if (sym_reg == CH_LPAREN)
            begin
                open_next = open_reg + CNT_W'(1);
            end
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
            if (top_reg == CH_LPAREN)
            begin
                open_next = open_reg - CNT_W'(1);
            end
        end
    end

    assign rd_ptr  = (count_next == '0) ? '0 : count_next - CNT_W'(1);
    assign rd_addr = rd_ptr[ADDR_W-1:0];
    assign wr_addr = count_reg[ADDR_W-1:0];
    assign ops     = count_reg - open_reg;

    always_comb
    begin
        unique case (cmd.src)
            SRC_SYM: emit_data = sym_reg;
            SRC_TOP: emit_data = top_reg;
            default: emit_data = 8'd0;
        endcase
    end

    // stack memory with registered top-of-stack read
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[wr_addr] <= sym_reg;
            top_reg      <= sym_reg;
        end
        else
        begin
            top_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sym_reg  <= in_symbol;
            last_reg <= in_last;
        end
        if (cmd.emit)
        begin
            out_symbol_reg <= emit_data;
            out_last_reg   <= cmd.emit_last;
            out_error_reg  <= cmd.err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            open_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            open_reg  <= open_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        status.sym_is_lparen = (sym_reg == CH_LPAREN);
        status.sym_is_rparen = (sym_reg == CH_RPAREN);
        status.sym_is_op     = (prec(sym_reg) != 2'd0);
        status.last          = last_reg;
        status.stack_empty   = (count_reg == '0);
        status.stack_full    = (count_reg == CNT_W'(STACK_DEPTH));
        status.ops_zero      = (ops == '0);
        status.ops_one       = (ops == CNT_W'(1));
        status.open_zero     = (open_reg == '0);
        status.top_is_lparen = (top_reg == CH_LPAREN);
        status.top_yields    = (prec(top_reg) >= prec(sym_reg));
        status.out_free      = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_symbol = out_symbol_reg;
    assign out_last   = out_last_reg;
    assign out_error  = out_error_reg;

endmodule

### sv/itp_ctrl.sv
// Controller of the infix-to-postfix converter: sequences accept, push, pop,
// emit and flush steps for one character at a time. Depends on itp_pkg.
module itp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  itp_pkg::status_t status,
    output itp_pkg::cmd_t    cmd
);
    import itp_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PROC  = 3'd1;
    localparam logic [2:0] S_CLOSE = 3'd2;
    localparam logic [2:0] S_OPPOP = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       emitted_reg, emitted_next;
    logic [2:0] after;
    logic       op_phase;

    assign in_ready = (state_reg == S_IDLE);
    assign after    = status.last ? S_FLUSH : S_IDLE;
    assign op_phase = (state_reg == S_OPPOP) || (state_reg == S_PROC && status.sym_is_op);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.load   = in_ready && in_valid;
        if (op_phase)
        begin
            if (!status.stack_empty && !status.top_is_lparen && status.top_yields)
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.pop    = 1'b1;
                    cmd.src    = SRC_TOP;
                    state_next = S_OPPOP;
                end
            end
            else if (!status.stack_full)
            begin
                cmd.push   = 1'b1;
                state_next = after;
            end
            else if (status.out_free)
            begin
                cmd.emit      = 1'b1;
                cmd.src       = SRC_SYM;
                cmd.err       = ERR_OVERFLOW;
                cmd.emit_last = status.last && status.ops_zero;
                state_next    = after;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd.load)
                    begin
                        state_next = S_PROC;
                    end
                end
                S_PROC:
                begin
                    if (status.sym_is_lparen)
                    begin
                        if (!status.stack_full)
                        begin
                            cmd.push   = 1'b1;
                            state_next = after;
                        end
                        else if (status.out_free)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.src       = SRC_SYM;
                            cmd.err       = ERR_OVERFLOW;
                            cmd.emit_last = status.last && status.ops_zero;
                            state_next    = after;
                        end
                    end
                    else if (status.sym_is_rparen)
                    begin
                        if (!status.open_zero)
                        begin
                            state_next = S_CLOSE;
                        end
                        else if (status.out_free)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.src       = SRC_SYM;
                            cmd.err       = ERR_UNMATCHED;
                            cmd.emit_last = status.last && status.ops_zero;
                            state_next    = after;
                        end
                    end
                    else if (status.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.src       = SRC_SYM;
                        cmd.emit_last = status.last && status.ops_zero;
                        state_next    = after;
                    end
                end
                S_CLOSE:
                begin
                    if (status.top_is_lparen)
                    begin
                        cmd.pop    = 1'b1;
                        state_next = after;
                    end
                    else if (status.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.pop       = 1'b1;
                        cmd.src       = SRC_TOP;
                        cmd.emit_last = status.last && status.ops_one;
                    end
                end
                S_FLUSH:
                begin
                    if (status.stack_empty)
                    begin
                        if (emitted_reg)
                        begin
                            state_next = S_IDLE;
                        end
                        else if (status.out_free)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.src       = SRC_ZERO;
                            cmd.emit_last = 1'b1;
                            state_next    = S_IDLE;
                        end
                    end
                    else if (status.top_is_lparen)
                    begin
                        cmd.pop = 1'b1;
                    end
                    else if (status.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.pop       = 1'b1;
                        cmd.src       = SRC_TOP;
                        cmd.emit_last = status.ops_one;
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    assign emitted_next = cmd.load ? 1'b0 : (cmd.emit ? 1'b1 : emitted_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            emitted_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            emitted_reg <= emitted_next;
        end
    end

endmodule

### sv/infix_to_postfix_converter_top.sv
// Top level of the infix-to-postfix converter: stream ports, controller and
// datapath. Depends on itp_pkg, itp_ctrl and itp_datapath.
//
// Takes one character per transfer and returns its postfix form, one character
// per output transfer, using an operator stack of STACK_DEPTH entries. One
// character is worked on at a time. An operand is emitted, a '(' is pushed, an
// unmatched ')' is emitted with an error. An operator first pops the stacked
// operators of equal or higher precedence, then is pushed. A matched ')' pops
// the operators above its '(' and then the '('. A character marked last then
// flushes the stack. The controller state machine makes at most one stack
// access per cycle, and output stalls hold it in a step that emits.
// The output register lets a result wait while the next character is taken.
// Errors are reported in m_axis_tuser: 1 stack overflow, 2 unmatched ')'.
module infix_to_postfix_converter_top #(
    parameter int STACK_DEPTH = itp_pkg::DEF_STACK_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] symbol
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_symbol
    output logic       m_axis_tlast,
    output logic [1:0] m_axis_tuser    // [1:0] error
);
    import itp_pkg::*;

    cmd_t    cmd;
    status_t status;

    itp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    itp_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_symbol  (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_symbol (m_axis_tdata),
        .out_last   (m_axis_tlast),
        .out_error  (m_axis_tuser)
    );

endmodule

### sv/itp_checker.sv
// Port-level checks for the infix-to-postfix converter, attached by bind.
// Depends on itp_pkg and infix_to_postfix_converter_top.
module itp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic [1:0] m_axis_tuser
);
    import itp_pkg::*;

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a character is in work");

    a_unmatched_is_close: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ERR_UNMATCHED |-> m_axis_tdata == CH_RPAREN)
        else $error("unmatched error without ')'");

    a_overflow_is_stackable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ERR_OVERFLOW |->
        m_axis_tdata == CH_LPAREN || m_axis_tdata == CH_MUL || m_axis_tdata == CH_DIV ||
        m_axis_tdata == CH_ADD || m_axis_tdata == CH_SUB)
        else $error("overflow error on a character that is never stacked");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
        $stable(m_axis_tuser))
        else $error("stalled output transfer changed");

endmodule

bind infix_to_postfix_converter_top itp_checker u_itp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
